// ===== rtl/core/rla_pkg.sv =====
// ----------------------------------------------------------------------------
// rla_pkg
// Shared types and codes for the ring label allocator: request actions,
// slot states, result status codes, number forms and the emit record.
// ----------------------------------------------------------------------------
package rla_pkg;

   // request actions
   localparam logic [1:0] ACT_CLEAR     = 2'd0;
   localparam logic [1:0] ACT_OPEN      = 2'd1;
   localparam logic [1:0] ACT_CLOSE_ALL = 2'd2;
   localparam logic [1:0] ACT_CLOSE_ONE = 2'd3;

   // slot states held in the table
   localparam logic [1:0] SLOT_FREE    = 2'd0;
   localparam logic [1:0] SLOT_OPEN    = 2'd1;
   localparam logic [1:0] SLOT_RETIRED = 2'd2;

   // result status
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_NO_PAIR   = 2'd2;
   localparam logic [1:0] STAT_NO_CLOSE  = 2'd3;

   // number forms
   localparam logic [1:0] FORM_DIGIT   = 2'd0;
   localparam logic [1:0] FORM_PERCENT = 2'd1;
   localparam logic [1:0] FORM_PAREN   = 2'd2;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_REUSE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 1'd1;

   // label widths: a slot label (slot + 1) fits in 11 bits for up to 1024 slots
   localparam int unsigned LABEL_W     = 10;
   localparam int unsigned LBL_SUM_W   = 11;
   localparam int unsigned BOND_W      = 3;
   localparam logic [LABEL_W-1:0] LABEL_MAX = 10'd1023;
   localparam logic [LABEL_W-1:0] ONE_DIGIT_LIMIT = 10'd10;
   localparam logic [LABEL_W-1:0] TWO_DIGIT_LIMIT = 10'd100;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_SCAN
   } eng_state_type;

   // one result on its way from the scan engine to the output register
   typedef struct packed {
      logic                 vld;
      logic [LBL_SUM_W-1:0] label_base;
      logic [BOND_W-1:0]    bond;
      logic                 opening;
      logic [1:0]           status;
      logic                 last;
   } emit_type;

endpackage

// ===== rtl/core/ring_label_allocator.sv =====
// ----------------------------------------------------------------------------
// ring_label_allocator
// Ring-closure label allocator: opens rings in the lowest free slot, closes
// them by atom or by atom pair, and frees or retires the slots it closes.
// ----------------------------------------------------------------------------
// Throughput: one request at a time, set by the scan over the slot table RAM,
//   one slot per cycle unless the output register stalls; an open or a pair
//   close ends early at the first hit, and a clear sweeps the whole table.
// Reset: synchronous; a clearing sweep follows reset, during which req_stall
//   stays high. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module ring_label_allocator #(
   parameter int unsigned SLOTS     = 64,
   parameter int unsigned ATOM_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_write,
   input  logic [rla_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rla_pkg::LABEL_W-1:0]         csr_wdata,
   // requests
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic [ATOM_BITS-1:0]                req_atom,
   input  logic [ATOM_BITS-1:0]                req_other_atom,
   input  logic [rla_pkg::BOND_W-1:0]          req_bond_code,
   // results
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rla_pkg::LABEL_W-1:0]         rsp_ring_label,
   output logic [1:0]                          rsp_number_form,
   output logic [rla_pkg::BOND_W-1:0]          rsp_closing_bond,
   output logic                                rsp_is_opening,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_last
);
   import rla_pkg::*;

   // configuration registers
   logic                reuse_ff, reuse_in;
   logic [LABEL_W-1:0]  offset_ff, offset_in;

   // scan engine to output register
   emit_type            emit;
   logic                emit_ready;

   // decode a register write; a write to an unknown index is dropped
   always_comb begin
      reuse_in  = reuse_ff;
      offset_in = offset_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_REUSE:  reuse_in  = csr_wdata[0];
            CSR_OFFSET: offset_in = csr_wdata;
            default: begin
               reuse_in  = reuse_ff;
               offset_in = offset_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reuse_ff  <= 1'b1;
         offset_ff <= '0;
      end else begin
         reuse_ff  <= reuse_in;
         offset_ff <= offset_in;
      end
   end

   // slot table and scan: one slot read per cycle unless the result is held back
   // by a stall, read-modify-write on a hit. Close-all holds back each closure
   // until the next one (or the end of the table) shows whether it is the last.
   rla_engine #(
      .SLOTS     (SLOTS),
      .ATOM_BITS (ATOM_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_atom       (req_atom),
      .req_other_atom (req_other_atom),
      .req_bond_code  (req_bond_code),
      .reuse_numbers  (reuse_ff),
      .emit           (emit),
      .emit_ready     (emit_ready)
   );

   // output register: offset, saturation and digit form, then hold under stall
   rla_result u_result (
      .clock            (clock),
      .reset            (reset),
      .emit             (emit),
      .emit_ready       (emit_ready),
      .label_offset     (offset_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ring_label   (rsp_ring_label),
      .rsp_number_form  (rsp_number_form),
      .rsp_closing_bond (rsp_closing_bond),
      .rsp_is_opening   (rsp_is_opening),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== rtl/core/rla_ram.sv =====
// ----------------------------------------------------------------------------
// rla_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rla_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rla_result.sv =====
// ----------------------------------------------------------------------------
// rla_result
// Output register: adds the label offset, saturates, classifies the number
// form and holds the request result until the receiver takes it.
// ----------------------------------------------------------------------------
module rla_result (
   input  logic                          clock,
   input  logic                          reset,
   input  rla_pkg::emit_type             emit,
   output logic                          emit_ready,
   input  logic [rla_pkg::LABEL_W-1:0]   label_offset,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rla_pkg::LABEL_W-1:0]   rsp_ring_label,
   output logic [1:0]                    rsp_number_form,
   output logic [rla_pkg::BOND_W-1:0]    rsp_closing_bond,
   output logic                          rsp_is_opening,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last
);
   import rla_pkg::*;

   logic                 valid_ff, valid_in;
   logic [LABEL_W-1:0]   label_ff, label_in;
   logic [1:0]           form_ff, form_in;
   logic [BOND_W-1:0]    bond_ff, bond_in;
   logic                 opening_ff;
   logic [1:0]           status_ff;
   logic                 last_ff;
   logic [LBL_SUM_W-1:0] sum;

   assign emit_ready = !valid_ff || !rsp_stall;

   always_comb begin
      sum      = emit.label_base + LBL_SUM_W'(label_offset);
      label_in = '0;
      form_in  = FORM_DIGIT;
      bond_in  = '0;
      if (emit.status == STAT_OK) begin
         label_in = (sum > LBL_SUM_W'(LABEL_MAX)) ? LABEL_MAX : sum[LABEL_W-1:0];
         bond_in  = emit.bond;
         if (label_in < ONE_DIGIT_LIMIT) begin
            form_in = FORM_DIGIT;
         end else if (label_in < TWO_DIGIT_LIMIT) begin
            form_in = FORM_PERCENT;
         end else begin
            form_in = FORM_PAREN;
         end
      end
      valid_in = emit.vld || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.vld) begin
         label_ff   <= label_in;
         form_ff    <= form_in;
         bond_ff    <= bond_in;
         opening_ff <= emit.opening;
         status_ff  <= emit.status;
         last_ff    <= emit.last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_ring_label   = label_ff;
   assign rsp_number_form  = form_ff;
   assign rsp_closing_bond = bond_ff;
   assign rsp_is_opening   = opening_ff;
   assign rsp_status       = status_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== rtl/core/rla_engine.sv =====
// ----------------------------------------------------------------------------
// rla_engine
// Slot table and scan sequencer: sweeps the table free, and scans it one
// slot a cycle (held while a result is stalled) to open, close by atom or close by pair.
// ----------------------------------------------------------------------------
module rla_engine #(
   parameter int unsigned SLOTS     = 64,
   parameter int unsigned ATOM_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_action,
   input  logic [ATOM_BITS-1:0]       req_atom,
   input  logic [ATOM_BITS-1:0]       req_other_atom,
   input  logic [rla_pkg::BOND_W-1:0] req_bond_code,
   input  logic                       reuse_numbers,
   output rla_pkg::emit_type          emit,
   input  logic                       emit_ready
);
   import rla_pkg::*;

   localparam int unsigned IDX_W  = $clog2(SLOTS);
   localparam int unsigned CNT_W  = IDX_W + 1;
   localparam int unsigned WORD_W = 2 * ATOM_BITS + BOND_W + 2;
   localparam logic [CNT_W-1:0] SCAN_END  = CNT_W'(SLOTS);
   localparam logic [CNT_W-1:0] SWEEP_END = CNT_W'(SLOTS - 1);

   eng_state_type state_ff, state_in;
   logic [1:0]           op_ff;
   logic [ATOM_BITS-1:0] atom_ff, other_ff;
   logic [BOND_W-1:0]    bond_ff;
   logic [CNT_W-1:0]     scan_ff;
   logic [IDX_W-1:0]     cur_ff;
   logic                 cur_vld_ff;
   logic                 pend_vld_ff;
   logic [LBL_SUM_W-1:0] pend_label_ff;
   logic [BOND_W-1:0]    pend_bond_ff;

   logic                 accept;
   logic [IDX_W-1:0]     rd_addr, wr_addr;
   logic                 wr_en;
   logic [WORD_W-1:0]    rd_data, wr_data;
   logic [ATOM_BITS-1:0] rec_close, rec_open;
   logic [BOND_W-1:0]    rec_bond;
   logic [1:0]           rec_status;
   logic [LBL_SUM_W-1:0] cur_label;
   logic                 hit, need_emit, hold, consume, done_hit, at_end, finish, issue;

   rla_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // word layout: status, bond, opening atom, closing atom
   assign rec_close  = rd_data[ATOM_BITS-1:0];
   assign rec_open   = rd_data[2*ATOM_BITS-1:ATOM_BITS];
   assign rec_bond   = rd_data[2*ATOM_BITS+BOND_W-1:2*ATOM_BITS];
   assign rec_status = rd_data[WORD_W-1:WORD_W-2];
   assign cur_label  = LBL_SUM_W'(cur_ff) + LBL_SUM_W'(1);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // outputs and datapath control
   always_comb begin
      hit = 1'b0;
      unique case (op_ff)
         ACT_OPEN:      hit = (rec_status == SLOT_FREE);
         ACT_CLOSE_ALL: hit = (rec_status == SLOT_OPEN) && (rec_close == atom_ff);
         ACT_CLOSE_ONE: hit = (rec_status == SLOT_OPEN) && (rec_close == atom_ff)
                              && (rec_open == other_ff);
         default:       hit = 1'b0;
      endcase
      need_emit = (op_ff == ACT_CLOSE_ALL) ? pend_vld_ff : 1'b1;
      hold      = (state_ff == ST_SCAN) && cur_vld_ff && hit && need_emit && !emit_ready;
      consume   = (state_ff == ST_SCAN) && cur_vld_ff && !hold;
      done_hit  = consume && hit && (op_ff != ACT_CLOSE_ALL);
      at_end    = (state_ff == ST_SCAN) && !cur_vld_ff && (scan_ff == SCAN_END);
      finish    = at_end && emit_ready;
      issue     = (state_ff == ST_SCAN) && !hold && !done_hit && (scan_ff != SCAN_END);

      rd_addr = hold ? cur_ff : scan_ff[IDX_W-1:0];

      wr_en   = 1'b0;
      wr_addr = cur_ff;
      wr_data = {SLOT_FREE, BOND_W'(0), {(2 * ATOM_BITS){1'b0}}};
      if (state_ff == ST_SWEEP) begin
         wr_en   = 1'b1;
         wr_addr = scan_ff[IDX_W-1:0];
      end else if (consume && hit) begin
         wr_en = 1'b1;
         if (op_ff == ACT_OPEN) begin
            wr_data = {SLOT_OPEN, bond_ff, atom_ff, other_ff};
         end else begin
            wr_data = {(reuse_numbers ? SLOT_FREE : SLOT_RETIRED), rec_bond,
                       rec_open, rec_close};
         end
      end

      emit            = '0;
      emit.status     = STAT_OK;
      emit.opening    = (op_ff == ACT_OPEN);
      emit.last       = 1'b1;
      if (consume && hit) begin
         if (op_ff == ACT_OPEN) begin
            emit.vld        = 1'b1;
            emit.label_base = cur_label;
         end else if (op_ff == ACT_CLOSE_ONE) begin
            emit.vld        = 1'b1;
            emit.label_base = cur_label;
            emit.bond       = rec_bond;
         end else begin
            // flush the previous closure, more follow
            emit.vld        = pend_vld_ff;
            emit.label_base = pend_label_ff;
            emit.bond       = pend_bond_ff;
            emit.last       = 1'b0;
         end
      end else if (finish) begin
         emit.vld = 1'b1;
         unique case (op_ff)
            ACT_OPEN:      emit.status = STAT_FULL;
            ACT_CLOSE_ONE: emit.status = STAT_NO_PAIR;
            ACT_CLOSE_ALL: begin
               if (pend_vld_ff) begin
                  emit.label_base = pend_label_ff;
                  emit.bond       = pend_bond_ff;
               end else begin
                  emit.status = STAT_NO_CLOSE;
               end
            end
            default:       emit.vld = 1'b0;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_action == ACT_CLEAR) ? ST_SWEEP : ST_SCAN;
            end
         end
         ST_SWEEP: begin
            if (scan_ff == SWEEP_END) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (done_hit || finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_SWEEP;
         scan_ff     <= '0;
         cur_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            scan_ff     <= '0;
            cur_vld_ff  <= 1'b0;
            pend_vld_ff <= 1'b0;
         end else if (state_ff == ST_SWEEP) begin
            scan_ff <= scan_ff + CNT_W'(1);
         end else if (issue) begin
            scan_ff    <= scan_ff + CNT_W'(1);
            cur_vld_ff <= 1'b1;
         end else if (!hold) begin
            cur_vld_ff <= 1'b0;
         end
         if (consume && hit && (op_ff == ACT_CLOSE_ALL)) begin
            pend_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_action;
         atom_ff  <= req_atom;
         other_ff <= req_other_atom;
         bond_ff  <= req_bond_code;
      end
      if (issue) begin
         cur_ff <= scan_ff[IDX_W-1:0];
      end
      if (consume && hit && (op_ff == ACT_CLOSE_ALL)) begin
         pend_label_ff <= cur_label;
         pend_bond_ff  <= rec_bond;
      end
   end

endmodule

// ===== test/ring_label_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_label_allocator_tb
// Self-checking bench for the ring label allocator. Opens, closes and
// clears are driven over the request channel, with random gaps on both
// sides. A shadow slot table predicts every result, which is checked field
// by field in order. The run covers several reuse and offset settings, a
// full table and saturated labels.
// ----------------------------------------------------------------------------
module ring_label_allocator_tb;
   import rla_pkg::*;

   localparam int unsigned SLOTS          = 64;
   localparam int unsigned ATOM_BITS      = 16;
   // the drain outlasts a request scan or a clear sweep of the whole table
   localparam int unsigned DRAIN_CYCLES   = SLOTS + 16;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned PHASE_ITEMS    = 50;

   typedef struct {
      logic [LABEL_W-1:0] ring_label;
      logic [1:0]         number_form;
      logic [BOND_W-1:0]  closing_bond;
      logic               is_opening;
      logic [1:0]         status;
      logic               last;
   } label_result_type;

   // Shadow slot table: predicts the labels that each request produces and
   // holds them until the block hands them out.
   class ring_label_book;
      logic [1:0]           slot_state [SLOTS];
      logic [ATOM_BITS-1:0] close_atom [SLOTS];
      logic [ATOM_BITS-1:0] open_atom  [SLOTS];
      logic [BOND_W-1:0]    slot_bond  [SLOTS];
      bit                   reuse_numbers;
      logic [LABEL_W-1:0]   label_offset;
      label_result_type     due_labels [$];
      int unsigned          failures;

      function new();
         foreach (slot_state[s]) slot_state[s] = SLOT_FREE;
         reuse_numbers = 1'b1;
         label_offset  = '0;
         failures      = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [LABEL_W-1:0] value);
         if (index == CSR_REUSE) reuse_numbers = value[0];
         else label_offset = value;
      endfunction

      function int unsigned pending();
         return due_labels.size();
      endfunction

      // queue a good result for slot s; the label saturates at the top code
      function void push_label(int s, logic [BOND_W-1:0] bnd, logic opening, logic fin);
         int unsigned      sum;
         label_result_type r;
         sum = s + 1 + label_offset;
         if (sum > LABEL_MAX) sum = LABEL_MAX;
         r.ring_label   = sum[LABEL_W-1:0];
         r.number_form  = (sum < ONE_DIGIT_LIMIT) ? FORM_DIGIT :
                          (sum < TWO_DIGIT_LIMIT) ? FORM_PERCENT : FORM_PAREN;
         r.closing_bond = bnd;
         r.is_opening   = opening;
         r.status       = STAT_OK;
         r.last         = fin;
         due_labels.push_back(r);
      endfunction

      function void push_error(logic [1:0] code, logic opening);
         label_result_type r;
         r.ring_label   = '0;
         r.number_form  = FORM_DIGIT;
         r.closing_bond = '0;
         r.is_opening   = opening;
         r.status       = code;
         r.last         = 1'b1;
         due_labels.push_back(r);
      endfunction

      function void release_slot(int s);
         slot_state[s] = reuse_numbers ? SLOT_FREE : SLOT_RETIRED;
      endfunction

      function void take_request(logic [1:0] action, logic [ATOM_BITS-1:0] atom,
                                 logic [ATOM_BITS-1:0] other, logic [BOND_W-1:0] bnd);
         int prev;
         prev = -1;
         case (action)
            ACT_CLEAR: begin
               foreach (slot_state[s]) slot_state[s] = SLOT_FREE;
            end
            ACT_OPEN: begin
               for (int s = 0; s < SLOTS; s++)
                  if (prev < 0 && slot_state[s] == SLOT_FREE) prev = s;
               if (prev < 0) begin
                  push_error(STAT_FULL, 1'b1);
               end else begin
                  slot_state[prev] = SLOT_OPEN;
                  close_atom[prev] = other;
                  open_atom[prev]  = atom;
                  slot_bond[prev]  = bnd;
                  push_label(prev, '0, 1'b1, 1'b0 | 1'b1);
               end
            end
            ACT_CLOSE_ALL: begin
               // every match but the last goes out without the last flag
               for (int s = 0; s < SLOTS; s++) begin
                  if (slot_state[s] == SLOT_OPEN && close_atom[s] == atom) begin
                     if (prev >= 0) begin
                        push_label(prev, slot_bond[prev], 1'b0, 1'b0);
                        release_slot(prev);
                     end
                     prev = s;
                  end
               end
               if (prev < 0) begin
                  push_error(STAT_NO_CLOSE, 1'b0);
               end else begin
                  push_label(prev, slot_bond[prev], 1'b0, 1'b1);
                  release_slot(prev);
               end
            end
            default: begin
               for (int s = 0; s < SLOTS; s++)
                  if (prev < 0 && slot_state[s] == SLOT_OPEN && close_atom[s] == atom &&
                      open_atom[s] == other) prev = s;
               if (prev < 0) begin
                  push_error(STAT_NO_PAIR, 1'b0);
               end else begin
                  push_label(prev, slot_bond[prev], 1'b0, 1'b1);
                  release_slot(prev);
               end
            end
         endcase
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
         if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            failures++;
         end
      endfunction

      function void match_label(label_result_type got);
         label_result_type want;
         if (due_labels.size() == 0) begin
            $error("unexpected result: label %0d status %0d", got.ring_label, got.status);
            failures++;
            return;
         end
         want = due_labels.pop_front();
         compare_field("ring_label",   16'(want.ring_label),   16'(got.ring_label));
         compare_field("number_form",  16'(want.number_form),  16'(got.number_form));
         compare_field("closing_bond", 16'(want.closing_bond), 16'(got.closing_bond));
         compare_field("is_opening",   16'(want.is_opening),   16'(got.is_opening));
         compare_field("status",       16'(want.status),       16'(got.status));
         compare_field("last",         16'(want.last),         16'(got.last));
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LABEL_W-1:0]   csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_action = ACT_CLEAR;
   logic [ATOM_BITS-1:0] req_atom = '0;
   logic [ATOM_BITS-1:0] req_other_atom = '0;
   logic [BOND_W-1:0]    req_bond_code = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [LABEL_W-1:0]   rsp_ring_label;
   logic [1:0]           rsp_number_form;
   logic [BOND_W-1:0]    rsp_closing_bond;
   logic                 rsp_is_opening;
   logic [1:0]           rsp_status;
   logic                 rsp_last;

   ring_label_book book = new();
   bit             send_calm = 1'b0;
   bit             take_calm = 1'b0;
   int unsigned    quiet_cycles = 0;

   ring_label_allocator #(
      .SLOTS     (SLOTS),
      .ATOM_BITS (ATOM_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_atom         (req_atom),
      .req_other_atom   (req_other_atom),
      .req_bond_code    (req_bond_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ring_label   (rsp_ring_label),
      .rsp_number_form  (rsp_number_form),
      .rsp_closing_bond (rsp_closing_bond),
      .rsp_is_opening   (rsp_is_opening),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Present one request after a random gap and hold it until it is taken.
   // Valid stays high on return so that a back-to-back request needs no
   // second assignment in the same step.
   task automatic send_request(input logic [1:0] action, input logic [ATOM_BITS-1:0] atom,
                               input logic [ATOM_BITS-1:0] other,
                               input logic [BOND_W-1:0] bnd);
      int unsigned gap;
      // flip now and then between gapped and back-to-back stretches
      if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_atom       <= atom;
      req_other_atom <= other;
      req_bond_code  <= bnd;
      do @(posedge clock); while (req_stall !== 1'b0);
      book.take_request(action, atom, other, bnd);
   endtask

   // Drop valid, wait for every predicted result, then let a trailing
   // clear finish its sweep so that the block is truly idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [LABEL_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      book.set_register(index, value);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input bit reuse, input logic [LABEL_W-1:0] offset);
      settle();
      write_register(CSR_REUSE, {{(LABEL_W-1){1'b0}}, reuse});
      write_register(CSR_OFFSET, offset);
   endtask

   // Hand-picked requests at reset settings: empty-table misses, extreme
   // atoms and bonds, a multi-slot close, lowest-slot pick on a duplicate
   // pair, slot reuse, a broken pair and a clear.
   task automatic run_directed();
      send_request(ACT_CLOSE_ALL, 16'h0000, 16'hFFFF, 3'd7);  // nothing open
      send_request(ACT_CLOSE_ONE, 16'hFFFF, 16'h0000, 3'd0);  // nothing open
      send_request(ACT_OPEN,      16'hFFFF, 16'h0000, 3'd7);
      send_request(ACT_OPEN,      16'h0000, 16'hFFFF, 3'd0);
      send_request(ACT_OPEN,      16'h1234, 16'hFFFF, 3'd5);
      send_request(ACT_OPEN,      16'hFFFF, 16'h0000, 3'd2);  // same pair as the first
      send_request(ACT_CLOSE_ALL, 16'hFFFF, 16'h0000, 3'd0);  // two closures
      send_request(ACT_CLOSE_ONE, 16'h0000, 16'hFFFF, 3'd0);  // lowest of two matches
      send_request(ACT_OPEN,      16'h00AA, 16'h0055, 3'd1);  // reuses the freed slot
      send_request(ACT_CLOSE_ONE, 16'h0000, 16'h1234, 3'd3);  // pair not found
      send_request(ACT_CLOSE_ALL, 16'h0000, 16'hAAAA, 3'd4);
      send_request(ACT_CLEAR,     16'h5555, 16'hAAAA, 3'd6);
      send_request(ACT_OPEN,      16'h8001, 16'h7FFE, 3'd3);
      send_request(ACT_CLOSE_ALL, 16'h7FFE, 16'h0000, 3'd0);
   endtask

   // Fill every slot with rings closing on one atom, overflow the table,
   // then close all at once: the widest burst the block can produce. With
   // retirement on, the emptied table still reports full until a clear.
   task automatic run_full_table();
      logic [ATOM_BITS-1:0] ring_end;
      logic [ATOM_BITS-1:0] open_at;
      logic [BOND_W-1:0]    bnd;
      ring_end = ATOM_BITS'($urandom);
      repeat (SLOTS + 1) begin
         open_at = ATOM_BITS'($urandom);
         bnd     = BOND_W'($urandom);
         send_request(ACT_OPEN, open_at, ring_end, bnd);
      end
      send_request(ACT_CLOSE_ALL, ring_end, open_at, bnd);
      send_request(ACT_OPEN, open_at, ring_end, bnd);
      send_request(ACT_CLEAR, ring_end, open_at, bnd);
      send_request(ACT_OPEN, open_at, ring_end, bnd);
      send_request(ACT_CLOSE_ONE, ring_end, open_at, bnd);
   endtask

   // One molecule: rings open and close among a small pool of atoms so
   // that most closes hit, with some noise and broken pairs mixed in.
   task automatic run_molecule(inout int unsigned items);
      logic [ATOM_BITS-1:0]   base;
      logic [ATOM_BITS-1:0]   close_at;
      logic [ATOM_BITS-1:0]   open_at;
      logic [BOND_W-1:0]      bnd;
      logic [1:0]             action;
      logic [2*ATOM_BITS-1:0] rings [$];
      int unsigned            steps;
      int unsigned            pick;
      int unsigned            roll;
      base  = ATOM_BITS'($urandom);
      steps = $urandom_range(4, 24);
      repeat (steps) begin
         roll = $urandom_range(0, 99);
         bnd  = BOND_W'($urandom);
         if (roll < 8) begin
            action   = 2'($urandom);
            open_at  = ATOM_BITS'($urandom);
            close_at = ATOM_BITS'($urandom);
            send_request(action, open_at, close_at, bnd);
         end else if (roll < 50 || rings.size() == 0) begin
            close_at = base + ATOM_BITS'($urandom_range(0, 7));
            open_at  = base + ATOM_BITS'($urandom_range(0, 7));
            send_request(ACT_OPEN, open_at, close_at, bnd);
            rings.push_back({close_at, open_at});
         end else if (roll < 72) begin
            pick     = $urandom_range(0, rings.size() - 1);
            close_at = rings[pick][2*ATOM_BITS-1:ATOM_BITS];
            open_at  = ATOM_BITS'($urandom);
            send_request(ACT_CLOSE_ALL, close_at, open_at, bnd);
            for (int i = rings.size() - 1; i >= 0; i--)
               if (rings[i][2*ATOM_BITS-1:ATOM_BITS] == close_at) rings.delete(i);
         end else begin
            pick = $urandom_range(0, rings.size() - 1);
            {close_at, open_at} = rings[pick];
            // break the odd pair on purpose
            if ($urandom_range(0, 7) == 0) open_at = open_at ^ ATOM_BITS'($urandom_range(1, 15));
            send_request(ACT_CLOSE_ONE, close_at, open_at, bnd);
            rings.delete(pick);
         end
         items++;
      end
      if ($urandom_range(0, 4) == 0) begin
         open_at  = ATOM_BITS'($urandom);
         close_at = ATOM_BITS'($urandom);
         send_request(ACT_CLEAR, open_at, close_at, bnd);
         items++;
      end
   endtask

   task automatic run_phase(input bit reuse, input logic [LABEL_W-1:0] offset);
      int unsigned items;
      items = 0;
      apply_setting(reuse, offset);
      while (items < PHASE_ITEMS) run_molecule(items);
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // the block sweeps its table after reset; the handshake absorbs it
      run_directed();
      apply_setting(1'b0, 10'd959);
      run_full_table();
      run_phase(1'b1, 10'd0);
      run_phase(1'b0, 10'd5);
      run_phase(1'b1, 10'd94);
      run_phase(1'b1, 10'd1000);   // labels run past the top code and saturate
      run_phase(1'b0, 10'd1023);
      run_phase(1'b1, LABEL_W'($urandom_range(0, 959)));
      run_phase(1'b0, LABEL_W'($urandom_range(0, 959)));
      settle();
      if (book.pending() == 0 && book.failures == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // Receiver: hold stall for a random count before each result, with
   // stretches of no stalling at all.
   initial begin : result_pacing
      int unsigned hold;
      forever begin
         if ($urandom_range(0, 29) == 0) take_calm = !take_calm;
         hold = take_calm ? 0 : $urandom_range(0, 16);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   // Check each result as it is taken.
   always @(posedge clock) begin : result_check
      label_result_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.ring_label   = rsp_ring_label;
         got.number_form  = rsp_number_form;
         got.closing_bond = rsp_closing_bond;
         got.is_opening   = rsp_is_opening;
         got.status       = rsp_status;
         got.last         = rsp_last;
         book.match_label(got);
      end
   end

   // Abort when neither channel has moved for far longer than any correct
   // request could take.
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $error("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule
